[rtl/core/r2i_pkg.sv]
// ----------------------------------------------------------------------------
// r2i_pkg
// Shared constants and types of the rgb to i420 converter.
// ----------------------------------------------------------------------------
package r2i_pkg;

  localparam int MAX_PAIRS = 512;
  localparam int MAX_ROWS  = 4096;

  localparam int PAIRS_W   = 10;
  localparam int ROWS_W    = 13;
  localparam int COL_W     = $clog2(2 * MAX_PAIRS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ADDR_W    = $clog2(MAX_PAIRS);

  localparam int COMP_W    = 8;
  localparam int SUM_W     = COMP_W + 1;
  localparam int LINE_W    = 3 * SUM_W;
  localparam int IN_W      = 3 * COMP_W;
  localparam int OUT_W     = 3 * COMP_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ROWS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_PER_LINE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_FRAME = 1'b1;

  localparam logic [15:0] CHROMA_BIAS = 16'd32896;
  localparam logic [7:0]  LUMA_OFS    = 8'd16;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [LINE_W-1:0] wdata;
  } mem_req_t;

endpackage

[rtl/core/r2i_line_mem.sv]
// ----------------------------------------------------------------------------
// r2i_line_mem
// Line buffer of even-row pair sums, one port, registered read.
// ----------------------------------------------------------------------------
module r2i_line_mem (
  input  logic                        clk,
  input  r2i_pkg::mem_req_t           req,
  output logic [r2i_pkg::LINE_W-1:0]  rdata
);
  import r2i_pkg::*;

  logic [LINE_W-1:0] mem [MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[rtl/core/rgb_to_i420_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_i420_converter
// RGB pixels in raster order to BT.601 limited-range Y with 2x2 Cb/Cr.
// Pipeline: three register stages, stage a, stage b and the output word.
// Throughput: one pixel per cycle unless the output stalls; the single-port
//   line buffer serves at most one access per pixel pair, a write on even
//   rows but the last or a read on odd rows.
// Reset: counters, held pixel and pipeline cleared, registers to 160 and 200;
//   the line buffer is not cleared.
// ----------------------------------------------------------------------------
module rgb_to_i420_converter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [r2i_pkg::IN_W-1:0]        in_tdata,   // red, green, blue
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [r2i_pkg::OUT_W-1:0]       out_tdata,  // luma, cb, cr
  output logic                            out_tuser,  // chroma_valid
  output logic                            out_tlast,  // frame_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [r2i_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [r2i_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import r2i_pkg::*;

  logic [PAIRS_W-1:0] pairs_r;
  logic [ROWS_W-1:0]  rows_r;
  logic [PAIRS_W-1:0] pairs_c;
  logic [ROWS_W-1:0]  rows_c;
  logic [PAIRS_W:0]   last_col_w;
  logic [ROWS_W-1:0]  last_row_w;
  logic [COL_W-1:0]   last_col;
  logic [ROW_W-1:0]   last_row;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [IN_W-1:0]    held_r;

  logic               acc;
  logic               row_end, frame_end, last_row_hit;
  logic [COMP_W-1:0]  in_r, in_g, in_b;
  logic [SUM_W-1:0]   sr, sg, sb;
  mem_req_t           mem_req;
  logic [LINE_W-1:0]  mem_q;

  // stage a
  logic               a_v_r;
  logic [COMP_W-1:0]  a_r_r, a_g_r, a_b_r;
  logic [SUM_W-1:0]   a_sr_r, a_sg_r, a_sb_r;
  logic               a_cv_r, a_odd_r, a_fe_r;
  // stage b
  logic               b_v_r;
  logic [15:0]        b_lacc_r;
  logic [COMP_W-1:0]  b_mr_r, b_mg_r, b_mb_r;
  logic               b_cv_r, b_fe_r;
  // output word
  logic               o_v_r;

  logic               o_ready, b_ready, a_ready;
  logic [SUM_W:0]     tr, tg, tb;
  logic [15:0]        lacc;
  logic [15:0]        cb_t, cr_t;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= PAIRS_W'(160);
      rows_r  <= ROWS_W'(200);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PAIRS_PER_LINE: pairs_r <= cfg_data[PAIRS_W-1:0];
        CFG_ROWS_PER_FRAME: rows_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pairs_r == '0) pairs_c = PAIRS_W'(1);
    else if (pairs_r > PAIRS_W'(MAX_PAIRS)) pairs_c = PAIRS_W'(MAX_PAIRS);
    else pairs_c = pairs_r;
    priority if (rows_r == '0) rows_c = ROWS_W'(1);
    else if (rows_r > ROWS_W'(MAX_ROWS)) rows_c = ROWS_W'(MAX_ROWS);
    else rows_c = rows_r;
  end

  assign last_col_w = {pairs_c, 1'b0} - (PAIRS_W + 1)'(1);
  assign last_row_w = rows_c - ROWS_W'(1);
  assign last_col   = last_col_w[COL_W-1:0];
  assign last_row   = last_row_w[ROW_W-1:0];

  // pipeline flow
  assign o_ready   = !o_v_r || out_tready;
  assign b_ready   = !b_v_r || o_ready;
  assign a_ready   = !a_v_r || b_ready;
  assign in_tready = a_ready;
  assign acc       = in_tvalid && a_ready;

  assign in_r = in_tdata[COMP_W-1:0];
  assign in_g = in_tdata[2*COMP_W-1:COMP_W];
  assign in_b = in_tdata[3*COMP_W-1:2*COMP_W];

  assign row_end      = col_r >= last_col;
  assign last_row_hit = row_r >= last_row;
  assign frame_end    = row_end && last_row_hit;

  assign sr = {1'b0, in_r} + {1'b0, held_r[3*COMP_W-1:2*COMP_W]};
  assign sg = {1'b0, in_g} + {1'b0, held_r[2*COMP_W-1:COMP_W]};
  assign sb = {1'b0, in_b} + {1'b0, held_r[COMP_W-1:0]};

  always_comb begin
    mem_req.addr  = col_r[COL_W-1:1];
    mem_req.wdata = {sr, sg, sb};
    mem_req.we    = acc && col_r[0] && !row_r[0] && !last_row_hit;
    mem_req.re    = acc && col_r[0] && row_r[0];
  end

  r2i_line_mem u_line_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_q)
  );

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (acc && !col_r[0]) begin
        held_r <= {in_r, in_g, in_b};
      end
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_r_r   <= in_r;
      a_g_r   <= in_g;
      a_b_r   <= in_b;
      a_sr_r  <= sr;
      a_sg_r  <= sg;
      a_sb_r  <= sb;
      a_cv_r  <= col_r[0] && (row_r[0] || last_row_hit);
      a_odd_r <= row_r[0];
      a_fe_r  <= frame_end;
    end
  end

  // block totals and luma products
  always_comb begin
    if (a_odd_r) begin
      tr = {1'b0, a_sr_r} + {1'b0, mem_q[3*SUM_W-1:2*SUM_W]};
      tg = {1'b0, a_sg_r} + {1'b0, mem_q[2*SUM_W-1:SUM_W]};
      tb = {1'b0, a_sb_r} + {1'b0, mem_q[SUM_W-1:0]};
    end else begin
      tr = {a_sr_r, 1'b0};
      tg = {a_sg_r, 1'b0};
      tb = {a_sb_r, 1'b0};
    end
    lacc = 16'(a_r_r) * 16'd66 + 16'(a_g_r) * 16'd129 + 16'(a_b_r) * 16'd25
         + 16'd128;
  end

  // stage b
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_v_r) begin
      b_lacc_r <= lacc;
      b_mr_r   <= tr[SUM_W:2];
      b_mg_r   <= tg[SUM_W:2];
      b_mb_r   <= tb[SUM_W:2];
      b_cv_r   <= a_cv_r;
      b_fe_r   <= a_fe_r;
    end
  end

  // chroma stays within 16..240, no clipping needed
  assign cb_t = CHROMA_BIAS + 16'(b_mb_r) * 16'd112 - 16'(b_mr_r) * 16'd38
              - 16'(b_mg_r) * 16'd74;
  assign cr_t = CHROMA_BIAS + 16'(b_mr_r) * 16'd112 - 16'(b_mg_r) * 16'd94
              - 16'(b_mb_r) * 16'd18;

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_ready) begin
      o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && b_v_r) begin
      out_tdata <= {b_cv_r ? cr_t[15:8] : {COMP_W{1'b0}},
                    b_cv_r ? cb_t[15:8] : {COMP_W{1'b0}},
                    LUMA_OFS + b_lacc_r[15:8]};
      out_tuser <= b_cv_r;
      out_tlast <= b_fe_r;
    end
  end

  assign out_tvalid = o_v_r;

endmodule

[rtl/core/r2i_checker.sv]
// ----------------------------------------------------------------------------
// r2i_checker
// Port-level checks of the rgb to i420 converter, bound to the top level.
// ----------------------------------------------------------------------------
module r2i_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [r2i_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       out_tuser,
  input  logic                       out_tlast
);
  import r2i_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // no chroma on words without a block
  a_no_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_W-1:COMP_W] == '0)
    else $error("chroma nonzero without chroma_valid");

  a_luma_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[COMP_W-1:0] >= 8'd16 && out_tdata[COMP_W-1:0] <= 8'd235)
    else $error("luma out of range");

  a_chroma_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[2*COMP_W-1:COMP_W] >= 8'd16 && out_tdata[2*COMP_W-1:COMP_W] <= 8'd240 &&
      out_tdata[3*COMP_W-1:2*COMP_W] >= 8'd16 && out_tdata[3*COMP_W-1:2*COMP_W] <= 8'd240)
    else $error("chroma out of range");

endmodule

bind rgb_to_i420_converter r2i_checker u_r2i_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[test/rgb_to_i420_converter_tb.sv]
// ----------------------------------------------------------------------------
// rgb_to_i420_converter_tb
// Self-checking bench for the rgb to i420 converter. Pixels are streamed in
// bursts with random gaps while the output side stalls on its own pattern.
// An in-order predictor of Y and 2x2 Cb/Cr keeps its own counters, held
// pixel and line of pair sums; every output word is compared field by field
// with the oldest predicted word. Directed tests cover the reset settings,
// a register change in the middle of a row, the clamped smallest and largest
// settings and the lone last row, then random frames of random size follow.
// ----------------------------------------------------------------------------
module rgb_to_i420_converter_tb;
  import r2i_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_PIXELS = 80;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       frame_end;
  } yuv_word_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  rgb_to_i420_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [PAIRS_W-1:0] pairs_setting;
  logic [ROWS_W-1:0]  rows_setting;
  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;
  logic [7:0]         held_r, held_g, held_b;
  logic [SUM_W-1:0]   line_r [MAX_PAIRS];
  logic [SUM_W-1:0]   line_g [MAX_PAIRS];
  logic [SUM_W-1:0]   line_b [MAX_PAIRS];

  yuv_word_t expected_yuv [$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  int        burst_left  = 0;
  int        ready_left  = 0;
  int        stall_left  = 0;

  function automatic logic [7:0] clip8(input int v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] chroma_from(input int k);
    int t;
    t = k + 128 + 32768;
    if (t < 0) return 8'd0;
    return clip8(t >> 8);
  endfunction

  function automatic logic [7:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic reset_model();
    pairs_setting = PAIRS_W'(160);
    rows_setting  = ROWS_W'(200);
    col_pos       = '0;
    row_pos       = '0;
    held_r        = '0;
    held_g        = '0;
    held_b        = '0;
  endtask

  task automatic predict_yuv(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             output yuv_word_t w);
    int pairs, rows, last_col, last_row;
    int sr, sg, sb, tr, tg, tb, mr, mg, mb;
    logic row_end, frame_end;
    logic [ADDR_W-1:0] idx;
    pairs = int'(pairs_setting);
    rows  = int'(rows_setting);
    if (pairs < 1) pairs = 1;
    if (pairs > MAX_PAIRS) pairs = MAX_PAIRS;
    if (rows < 1) rows = 1;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    last_col  = 2 * pairs - 1;
    last_row  = rows - 1;
    row_end   = int'(col_pos) >= last_col;
    frame_end = row_end && (int'(row_pos) >= last_row);
    w = '0;
    w.luma = clip8(16 + ((66 * int'(r) + 129 * int'(g) + 25 * int'(b) + 128) >> 8));
    idx = col_pos[COL_W-1:1];
    if (!col_pos[0]) begin
      held_r = r;
      held_g = g;
      held_b = b;
    end else begin
      sr = int'(r) + int'(held_r);
      sg = int'(g) + int'(held_g);
      sb = int'(b) + int'(held_b);
      if (!row_pos[0] && int'(row_pos) < last_row) begin
        line_r[idx] = SUM_W'(sr);
        line_g[idx] = SUM_W'(sg);
        line_b[idx] = SUM_W'(sb);
      end else begin
        if (row_pos[0]) begin
          tr = sr + int'(line_r[idx]);
          tg = sg + int'(line_g[idx]);
          tb = sb + int'(line_b[idx]);
        end else begin
          // lone last row pairs with itself
          tr = 2 * sr;
          tg = 2 * sg;
          tb = 2 * sb;
        end
        mr = tr >> 2;
        mg = tg >> 2;
        mb = tb >> 2;
        w.cb = chroma_from(-38 * mr - 74 * mg + 112 * mb);
        w.cr = chroma_from(112 * mr - 94 * mg - 18 * mb);
        w.chroma_valid = 1'b1;
      end
    end
    if (row_end) begin
      col_pos = '0;
      row_pos = frame_end ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    w.frame_end = frame_end;
  endtask

  task automatic wait_drained();
    while (expected_yuv.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PAIRS_PER_LINE) pairs_setting = data[PAIRS_W-1:0];
    else if (idx == CFG_ROWS_PER_FRAME) rows_setting = data[ROWS_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    yuv_word_t w;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 32);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    predict_yuv(r, g, b, w);
    expected_yuv.push_back(w);
    burst_left--;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid  <= 1'b0;
    burst_left = 0;
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(pick_component(), pick_component(), pick_component());
  endtask

  // reset settings, first row is buffered only
  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_random_pixels(2);
    stop_sending();
  endtask

  // narrower row while mid-row, then odd row and lone last row
  task automatic test_mid_frame_change();
    write_reg(CFG_PAIRS_PER_LINE, CFG_DATA_W'(2));
    write_reg(CFG_ROWS_PER_FRAME, CFG_DATA_W'(3));
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00);
    stop_sending();
  endtask

  // zero settings clamp to one pair and one row
  task automatic test_smallest_frame();
    write_reg(CFG_PAIRS_PER_LINE, '0);
    write_reg(CFG_ROWS_PER_FRAME, '0);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    stop_sending();
  endtask

  // all-ones write masks and clamps to the widest line, one lone row
  task automatic test_widest_line();
    write_reg(CFG_PAIRS_PER_LINE, '1);
    write_reg(CFG_ROWS_PER_FRAME, CFG_DATA_W'(1));
    send_random_pixels(2 * MAX_PAIRS);
    stop_sending();
  endtask

  // bits above the pairs field are dropped, rows clamp to the maximum;
  // a few rows in, the frame is cut short so the current row is the last
  task automatic test_tallest_frame();
    write_reg(CFG_PAIRS_PER_LINE, CFG_DATA_W'(13'h0401));
    write_reg(CFG_ROWS_PER_FRAME, '1);
    send_random_pixels(16);
    stop_sending();
    write_reg(CFG_ROWS_PER_FRAME, CFG_DATA_W'(9));
    send_random_pixels(2);
    stop_sending();
  endtask

  task automatic test_random_frames();
    int sent, pairs, rows, n;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: pairs = 0;
        1: pairs = $urandom_range(9, 16);
        default: pairs = $urandom_range(1, 8);
      endcase
      rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      write_reg(CFG_PAIRS_PER_LINE, CFG_DATA_W'(pairs));
      write_reg(CFG_ROWS_PER_FRAME, CFG_DATA_W'(rows));
      n = 2 * ((pairs < 1) ? 1 : pairs) * ((rows < 1) ? 1 : rows);
      send_random_pixels(n);
      stop_sending();
      sent += n;
    end
  endtask

  // output stall pattern
  always @(negedge clk) begin
    if (ready_left > 0) begin
      out_tready <= 1'b1;
      ready_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      ready_left = $urandom_range(1, 40);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    yuv_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_yuv.size() == 0) begin
        $error("output word with nothing expected");
        fail_count++;
      end else begin
        w = expected_yuv.pop_front();
        if (out_tdata[7:0] !== w.luma) begin
          $error("luma: expected %0d, got %0d", w.luma, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tuser !== w.chroma_valid) begin
          $error("chroma_valid: expected %0d, got %0d", w.chroma_valid, out_tuser);
          fail_count++;
        end
        if (out_tdata[15:8] !== w.cb) begin
          $error("cb: expected %0d, got %0d", w.cb, out_tdata[15:8]);
          fail_count++;
        end
        if (out_tdata[23:16] !== w.cr) begin
          $error("cr: expected %0d, got %0d", w.cr, out_tdata[23:16]);
          fail_count++;
        end
        if (out_tlast !== w.frame_end) begin
          $error("frame_end: expected %0d, got %0d", w.frame_end, out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** rgb_to_i420_converter: FAILED **");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_mid_frame_change();
    test_smallest_frame();
    test_widest_line();
    test_tallest_frame();
    test_random_frames();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** rgb_to_i420_converter: PASSED **");
    end else begin
      $display("** rgb_to_i420_converter: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/r2i_pkg.sv
rtl/core/r2i_line_mem.sv
rtl/core/rgb_to_i420_converter.sv
rtl/core/r2i_checker.sv
test/rgb_to_i420_converter_tb.sv
